/* design/assert_macros.svh */
// Assertion macros shared by the disk DMA FIFO controller modules.
// Depends on the using module having aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is held.
`define DDSF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define DDSF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

/* design/ddsf_pkg.sv */
// Shared types, codes and FIFO helper functions for the disk DMA FIFO controller.
// No dependencies.
package ddsf_pkg;

    localparam int FIFO_BYTES = 6;
    localparam int FIFO_W     = 8 * FIFO_BYTES;
    localparam int CNT_W      = $clog2(FIFO_BYTES + 1);

    localparam logic [17:0] WATCHDOG_LIMIT = 18'(8 * 20000);
    localparam logic [15:0] SYNC_RESET     = 16'h4489;

    // commands
    localparam logic [1:0] CMD_DISK = 2'd0;
    localparam logic [1:0] CMD_DMA  = 2'd1;
    localparam logic [1:0] CMD_SET  = 2'd2;

    // modes
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_WAIT  = 3'd1;
    localparam logic [2:0] MODE_READ  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_FLUSH = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_MEM    = 2'd1;
    localparam logic [1:0] KIND_DISK   = 2'd2;

    // config register indexes
    localparam logic CFG_SYNC_WORD = 1'b0;
    localparam logic CFG_AUTO_SYNC = 1'b1;

    typedef struct packed {
        logic [15:0] sync_word;
        logic        auto_sync;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  disk_byte;
        logic        drive_present;
        logic [15:0] mem_word;
        logic [13:0] new_length;
        logic [2:0]  new_mode;
    } item_t;

    typedef struct packed {
        logic [FIFO_W-1:0] bytes;
        logic [CNT_W-1:0]  count;
    } fifo_t;

    // everything one item produces; multi marks a flush burst read from bytes
    typedef struct packed {
        logic [1:0]        kind;
        logic [15:0]       data;
        logic [FIFO_W-1:0] bytes;
        logic              multi;
        logic [CNT_W-1:0]  n;
        logic              sync_irq;
        logic              block_irq;
        logic              word_taken;
        logic [2:0]        mode_now;
        logic [CNT_W-1:0]  level;
    } burst_t;

    // push one byte; a full FIFO first drops its oldest word
    function automatic fifo_t fifo_push(fifo_t f, logic [7:0] b);
        fifo_t r;
        r = f;
        if (f.count >= CNT_W'(FIFO_BYTES)) begin
            r.count = CNT_W'(FIFO_BYTES - 2);
        end
        r.bytes = {f.bytes[FIFO_W-9:0], b};
        r.count = r.count + 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] get_byte(logic [FIFO_W-1:0] bytes, logic [CNT_W-1:0] idx);
        logic [7:0] r;
        r = '0;
        for (int i = 0; i < FIFO_BYTES; i++) begin
            if (idx == CNT_W'(i)) begin
                r = bytes[8*i +: 8];
            end
        end
        return r;
    endfunction

endpackage

/* design/disk_dma_sync_fifo_controller_unit.sv */
// Top level of the floppy disk DMA controller with sync detection and byte FIFO.
// Depends on ddsf_pkg, ddsf_core and ddsf_out.
//
// Usage:
//   s_ channel: one command word per handshake. s_tuser is the command
//   (disk tick, DMA slot, set mode). s_tdata carries the drive byte, drive
//   present flag, memory word, new length and new mode.
//   m_ channel: result words. m_tuser is the result kind (status, word to
//   memory, byte to disk); m_tlast marks the last word of a command.
//   cfg_ port: sync word (index 0) and watchdog enable (index 1), written on any
//   edge with cfg_wr_en high; the user must write only while the block is idle (unenforced).
// Path: the first result word of a command reaches m_ through the input
//   register, then the result register.
// Throughput: one command per cycle when each gives one word and m_tready
//   stays high. The final write flush gives one word per FIFO byte (up to
//   six), and s_ stalls until the result register has handed out the last
//   of them, one word a cycle.
// Stall: with m_tready low the result register holds and the input
//   register still takes one more command before s_tready drops.
// Reset: aresetn low clears mode, length, shifter, FIFO and watchdog, and
//   loads sync word 0x4489 with the watchdog off. No words are in flight.

module disk_dma_sync_fifo_controller_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // command channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // disk_byte[7:0], drive_present[8], mem_word[24:9],
                                   // new_length[38:25], new_mode[41:39], zero[47:42]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // data[15:0], sync_irq[16], block_irq[17], word_taken[18],
                                   // mode_now[21:19], fifo_level[24:22], zero[31:25]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast,
    // configuration writes
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    ddsf_pkg::cfg_t   cfg_reg;
    ddsf_pkg::item_t  s_item;
    ddsf_pkg::burst_t burst;
    logic             burst_valid;
    logic             burst_ready;
    logic [15:0]      r_data;
    logic             r_sync;
    logic             r_block;
    logic             r_taken;
    logic [2:0]       r_mode;
    logic [2:0]       r_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_word <= ddsf_pkg::SYNC_RESET;
            cfg_reg.auto_sync <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                ddsf_pkg::CFG_SYNC_WORD: cfg_reg.sync_word <= cfg_wdata;
                ddsf_pkg::CFG_AUTO_SYNC: cfg_reg.auto_sync <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // unpack the command word
    assign s_item.command       = s_tuser;
    assign s_item.disk_byte     = s_tdata[7:0];
    assign s_item.drive_present = s_tdata[8];
    assign s_item.mem_word      = s_tdata[24:9];
    assign s_item.new_length    = s_tdata[38:25];
    assign s_item.new_mode      = s_tdata[41:39];

    ddsf_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_item      (s_item),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst)
    );

    ddsf_out u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .burst_valid (burst_valid),
        .burst_ready (burst_ready),
        .burst       (burst),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .kind        (m_tuser),
        .data        (r_data),
        .sync_irq    (r_sync),
        .block_irq   (r_block),
        .word_taken  (r_taken),
        .mode_now    (r_mode),
        .fifo_level  (r_level)
    );

    assign m_tdata = {7'b0, r_level, r_mode, r_taken, r_block, r_sync, r_data};

endmodule

/* design/ddsf_core.sv */
// Input register, controller state and the single-pass next-state logic.
// Depends on ddsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ddsf_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  ddsf_pkg::cfg_t  cfg,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  ddsf_pkg::item_t s_item,
    output logic            burst_valid,
    input  logic            burst_ready,
    output ddsf_pkg::burst_t burst
);

    localparam logic [ddsf_pkg::CNT_W-1:0] CNT_W_ONE   = ddsf_pkg::CNT_W'(1);
    localparam logic [ddsf_pkg::CNT_W-1:0] CNT_W_TWO   = ddsf_pkg::CNT_W'(2);
    localparam logic [ddsf_pkg::CNT_W-1:0] CNT_W_FREE2 = ddsf_pkg::CNT_W'(ddsf_pkg::FIFO_BYTES - 2);

    logic                      in_valid_reg, in_valid_next;
    ddsf_pkg::item_t           item_reg;
    logic [2:0]                mode_reg, mode_next;
    logic [13:0]               words_reg, words_next;
    logic [15:0]               shifter_reg, shifter_next;
    logic [2:0]                bitcnt_reg, bitcnt_next;
    ddsf_pkg::fifo_t           fifo_reg, fifo_next;
    logic [17:0]               wdog_reg, wdog_next;
    logic                      fire;

    assign s_tready    = !in_valid_reg || burst_ready;
    assign fire        = in_valid_reg && burst_ready;
    assign burst_valid = in_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    // next state and result burst for the item in the input register
    always_comb begin
        logic [7:0]      dbyte;
        logic            hit;
        ddsf_pkg::fifo_t f_v;
        logic [15:0]     sh_v;
        logic [2:0]      bc_v;
        logic [17:0]     wd_v;
        logic [2:0]      mode_v;

        dbyte  = item_reg.drive_present ? item_reg.disk_byte : 8'h00;
        f_v    = fifo_reg;
        sh_v   = shifter_reg;
        bc_v   = bitcnt_reg;
        wd_v   = wdog_reg;
        mode_v = mode_reg;
        hit    = 1'b0;
        words_next = words_reg;

        burst            = '0;
        burst.kind       = ddsf_pkg::KIND_STATUS;
        burst.n          = CNT_W_ONE;

        case (item_reg.command)
            ddsf_pkg::CMD_DISK: begin
                if (mode_reg <= ddsf_pkg::MODE_READ) begin
                    // eight bits, MSB first
                    for (int i = 7; i >= 0; i--) begin
                        sh_v = {sh_v[14:0], dbyte[i]};
                        if (bc_v == 3'd7) begin
                            f_v = ddsf_pkg::fifo_push(f_v, sh_v[7:0]);
                        end
                        bc_v = bc_v + 3'd1;
                        hit  = (sh_v == cfg.sync_word);
                        if (!hit && cfg.auto_sync) begin
                            if (wd_v > ddsf_pkg::WATCHDOG_LIMIT) begin
                                hit = 1'b1;
                            end
                            wd_v = wd_v + 18'd1;
                        end
                        if (hit) begin
                            burst.sync_irq = 1'b1;
                            if (mode_v == ddsf_pkg::MODE_WAIT) begin
                                bc_v   = '0;
                                f_v    = '0;
                                mode_v = ddsf_pkg::MODE_READ;
                            end
                            wd_v = '0;
                        end
                    end
                end else if (fifo_reg.count == '0) begin
                    if (mode_reg == ddsf_pkg::MODE_FLUSH) begin
                        mode_v     = ddsf_pkg::MODE_OFF;
                        words_next = '0;
                    end
                end else begin
                    f_v.count = fifo_reg.count - 1'b1;
                    if (item_reg.drive_present) begin
                        burst.kind = ddsf_pkg::KIND_DISK;
                        burst.data = {8'h00, ddsf_pkg::get_byte(fifo_reg.bytes, f_v.count)};
                    end
                end
            end
            ddsf_pkg::CMD_DMA: begin
                if (words_reg != '0 && mode_reg == ddsf_pkg::MODE_READ) begin
                    if (fifo_reg.count >= CNT_W_TWO) begin
                        f_v.count  = fifo_reg.count - CNT_W_TWO;
                        burst.kind = ddsf_pkg::KIND_MEM;
                        burst.data = {ddsf_pkg::get_byte(fifo_reg.bytes, f_v.count + 1'b1),
                                      ddsf_pkg::get_byte(fifo_reg.bytes, f_v.count)};
                        words_next = words_reg - 14'd1;
                        if (words_next == '0) begin
                            burst.block_irq = 1'b1;
                            mode_v          = ddsf_pkg::MODE_OFF;
                        end
                    end
                end else if (words_reg != '0 && mode_reg == ddsf_pkg::MODE_WRITE) begin
                    if (fifo_reg.count <= CNT_W_FREE2) begin
                        f_v = ddsf_pkg::fifo_push(f_v, item_reg.mem_word[15:8]);
                        f_v = ddsf_pkg::fifo_push(f_v, item_reg.mem_word[7:0]);
                        burst.word_taken = 1'b1;
                        words_next = words_reg - 14'd1;
                        if (words_next == '0) begin
                            // last word: the whole FIFO goes to the disk if a drive is present, and is emptied
                            burst.block_irq = 1'b1;
                            if (item_reg.drive_present) begin
                                burst.kind  = ddsf_pkg::KIND_DISK;
                                burst.multi = 1'b1;
                                burst.n     = f_v.count;
                                burst.bytes = f_v.bytes;
                            end
                            f_v.count = '0;
                            mode_v    = ddsf_pkg::MODE_OFF;
                        end
                    end
                end
            end
            ddsf_pkg::CMD_SET: begin
                if (item_reg.new_mode > ddsf_pkg::MODE_FLUSH) begin
                    mode_v     = ddsf_pkg::MODE_OFF;
                    words_next = '0;
                end else begin
                    mode_v     = item_reg.new_mode;
                    words_next = item_reg.new_length;
                end
            end
            default: begin
            end
        endcase

        burst.mode_now = mode_v;
        burst.level    = f_v.count;

        mode_next    = mode_v;
        shifter_next = sh_v;
        bitcnt_next  = bc_v;
        fifo_next    = f_v;
        wdog_next    = wd_v;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            mode_reg     <= ddsf_pkg::MODE_OFF;
            words_reg    <= '0;
            shifter_reg  <= '0;
            bitcnt_reg   <= '0;
            fifo_reg     <= '0;
            wdog_reg     <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            if (fire) begin
                mode_reg    <= mode_next;
                words_reg   <= words_next;
                shifter_reg <= shifter_next;
                bitcnt_reg  <= bitcnt_next;
                fifo_reg    <= fifo_next;
                wdog_reg    <= wdog_next;
            end
        end
    end

    `DDSF_ASSERT(a_fifo_bound, fifo_reg.count <= ddsf_pkg::CNT_W'(ddsf_pkg::FIFO_BYTES), "FIFO count above depth")
    `DDSF_ASSERT(a_block_off, fire && burst.block_irq |=> mode_reg == ddsf_pkg::MODE_OFF && words_reg == '0, "block done did not turn DMA off")
    `DDSF_ASSERT(a_item_hold, in_valid_reg && !burst_ready |=> in_valid_reg && $stable(item_reg), "held item lost while result stage full")

endmodule

/* design/ddsf_out.sv */
// Result stage: holds one item's burst and hands it out one word per cycle while m_tready is high.
// Depends on ddsf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ddsf_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             burst_valid,
    output logic             burst_ready,
    input  ddsf_pkg::burst_t burst,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic             m_tlast,
    output logic [1:0]       kind,
    output logic [15:0]      data,
    output logic             sync_irq,
    output logic             block_irq,
    output logic             word_taken,
    output logic [2:0]       mode_now,
    output logic [2:0]       fifo_level
);

    logic                          valid_reg, valid_next;
    ddsf_pkg::burst_t              burst_reg;
    logic [ddsf_pkg::CNT_W-1:0]    left_reg, left_next;
    logic                          load;

    localparam logic [ddsf_pkg::CNT_W-1:0] ONE = ddsf_pkg::CNT_W'(1);

    assign m_tlast     = (left_reg == ONE);
    assign burst_ready = !valid_reg || (m_tready && m_tlast);
    assign load        = burst_valid && burst_ready;

    always_comb begin
        valid_next = valid_reg;
        left_next  = left_reg;
        if (burst_ready) begin
            valid_next = burst_valid;
            if (burst_valid) begin
                left_next = burst.n;
            end
        end else if (m_tready) begin
            left_next = left_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= ONE;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            burst_reg <= burst;
        end
    end

    // flush bursts go out oldest byte first
    assign m_tvalid   = valid_reg;
    assign kind       = burst_reg.kind;
    assign data       = burst_reg.multi
                      ? {8'h00, ddsf_pkg::get_byte(burst_reg.bytes, left_reg - 1'b1)}
                      : burst_reg.data;
    assign sync_irq   = burst_reg.sync_irq;
    assign block_irq  = burst_reg.block_irq;
    assign word_taken = burst_reg.word_taken;
    assign mode_now   = burst_reg.mode_now;
    assign fifo_level = 3'(burst_reg.level);

    `DDSF_ASSERT(a_left_range, valid_reg |-> left_reg != '0 && left_reg <= ddsf_pkg::CNT_W'(ddsf_pkg::FIFO_BYTES), "word counter out of range")
    `DDSF_ASSERT(a_load_count, load |=> left_reg == $past(burst.n) && valid_reg, "burst length not loaded")
    `DDSF_ASSERT(a_single, valid_reg && !burst_reg.multi |-> left_reg == ONE, "single-word result with words left")

endmodule
